### rtl/gracc_pkg.sv
package gracc_pkg;

  localparam int AddrW   = 64;
  localparam int PermW   = 3;
  localparam int SlotW   = 4;
  localparam int CountW  = 5;
  localparam int StatusW = 2;

  typedef enum logic [0:0] {
    OP_CHECK = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_WRAP     = 2'd1,
    ST_DENIED   = 2'd2,
    ST_UNMAPPED = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_REGION_COUNT = 1'b0,
    CFG_IMAGE_BASE   = 1'b1
  } cfg_idx_e;

  // Request payload, one field per input of the block.
  typedef struct packed {
    logic [0:0]       op;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] access_size;
    logic [PermW-1:0] permission;
    logic [SlotW-1:0] region_slot;
    logic [AddrW-1:0] region_start;
    logic [AddrW-1:0] region_length;
    logic [PermW-1:0] region_perms;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   byte_offset;
  } rsp_t;

  typedef struct packed {
    logic [0:0]       index;
    logic [AddrW-1:0] data;
  } cfg_t;

  // Item as it travels down the region walk.
  typedef struct packed {
    logic             wr;
    logic             done;
    status_e          status;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] cursor;
    logic [AddrW-1:0] acc_end;
    logic [PermW-1:0] perm;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] rstart;
    logic [AddrW:0]   rend;   // carry bit marks a region reaching the top
    logic [PermW-1:0] rperms;
  } walk_t;

endpackage

### rtl/gracc_if.sv
interface gracc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/gracc_front.sv
module gracc_front import gracc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  req_t  in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output walk_t out_data_o
);

  logic       valid_q;
  walk_t      item_q;
  walk_t      item_d;
  logic [AddrW:0] acc_sum;
  logic [AddrW:0] reg_sum;
  logic       is_wr;
  logic       zero_len;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

  always_comb begin
    acc_sum  = {1'b0, in_data_i.address} + {1'b0, in_data_i.access_size};
    reg_sum  = {1'b0, in_data_i.region_start} + {1'b0, in_data_i.region_length};
    is_wr    = (in_data_i.op == OP_WRITE);
    zero_len = (in_data_i.access_size == '0);

    item_d.wr      = is_wr;
    // writes, empty accesses and wrapping ranges are settled here
    item_d.done    = is_wr || zero_len || acc_sum[AddrW];
    item_d.status  = (!is_wr && !zero_len && acc_sum[AddrW]) ? ST_WRAP : ST_OK;
    item_d.addr    = in_data_i.address;
    item_d.cursor  = in_data_i.address;
    item_d.acc_end = acc_sum[AddrW-1:0];
    item_d.perm    = in_data_i.permission;
    item_d.slot    = in_data_i.region_slot;
    item_d.rstart  = in_data_i.region_start;
    item_d.rend    = reg_sum;
    item_d.rperms  = in_data_i.region_perms;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

### rtl/gracc_cell.sv
module gracc_cell import gracc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] region_count_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  walk_t             in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output walk_t             out_data_o
);

  logic             valid_q;
  walk_t            item_q;
  walk_t            item_d;
  logic [AddrW-1:0] start_q;
  logic [AddrW:0]   end_q;
  logic [PermW-1:0] perm_q;
  logic             active;
  logic             skip;
  logic             take;
  logic             hit_slot;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;
  assign take        = in_valid_i && in_ready_o;
  assign active      = int'(region_count_i) > IDX;
  assign hit_slot    = int'(in_data_i.slot) == IDX;

  always_comb begin
    item_d = in_data_i;
    skip   = end_q <= {1'b0, in_data_i.cursor};
    if (!in_data_i.wr && !in_data_i.done && active && !skip) begin
      priority if (start_q > in_data_i.cursor) begin
        item_d.done   = 1'b1;
        item_d.status = ST_UNMAPPED;
      end else if ((perm_q & in_data_i.perm) != in_data_i.perm) begin
        item_d.done   = 1'b1;
        item_d.status = ST_DENIED;
      end else if ({1'b0, in_data_i.acc_end} <= end_q) begin
        item_d.cursor = in_data_i.acc_end;
        item_d.done   = 1'b1;
        item_d.status = ST_OK;
      end else begin
        item_d.cursor = end_q[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Table entry lives in its own stage; a write lands as it passes, so
  // checks ahead of it keep the old entry and checks behind see the new one.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
    if (take && in_data_i.wr && hit_slot) begin
      start_q <= in_data_i.rstart;
      end_q   <= in_data_i.rend;
      perm_q  <= in_data_i.rperms;
    end
  end

endmodule

### rtl/gracc_back.sv
module gracc_back import gracc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] image_base_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  walk_t            in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_data_o
);

  logic    valid_q;
  rsp_t    rsp_q;
  rsp_t    rsp_d;
  status_e st;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = rsp_q;

  always_comb begin
    // a check still open after the last region ran out of table
    st = in_data_i.done ? in_data_i.status : ST_UNMAPPED;
    rsp_d.status      = st;
    rsp_d.byte_offset = (!in_data_i.wr && st == ST_OK) ?
                        in_data_i.addr - image_base_i : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

### rtl/guest_region_access_check.sv
// Guest region access check: memory protection check of guest accesses.
// Channels: req_i carries one item per transfer, either a region table
// write (op set) or an access check; rsp_o returns exactly one result per
// item, in order; cfg_i writes region_count (index 0) and image_base
// (index 1) and is always ready, but write it only while the block is idle.
// Structure: one entry stage (range end, wrap test, region end), one stage
// per table slot that holds that slot's region and advances the cursor, and
// one output stage that forms the image offset.
// Depth: MAX_REGIONS + 2 register stages lie between a request transfer and
// its result on rsp_o. Throughput: one item per cycle while rsp_o is taken;
// each stage holds one item, so the walk over the table is spread over
// MAX_REGIONS stages.
// Reset: all stages drop their items, region_count and image_base clear to
// zero; the region table holds no value until written.
// Stall: when rsp_o is not taken, stages fill from the back and hold; each
// empty stage still takes a transfer, and nothing is lost or repeated.
module guest_region_access_check import gracc_pkg::*; #(
  parameter int MAX_REGIONS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gracc_stream_if.sink   req_i,
  gracc_stream_if.sink   cfg_i,
  gracc_stream_if.source rsp_o
);

  logic [CountW-1:0] region_count_q;
  logic [AddrW-1:0]  image_base_q;

  // Stage k feeds slot stage k; the last entry feeds the output stage.
  logic  stg_valid [MAX_REGIONS+1];
  logic  stg_ready [MAX_REGIONS+1];
  walk_t stg_data  [MAX_REGIONS+1];

  // Configuration registers: always accept, decode index.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= '0;
      image_base_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.data.index))
        CFG_REGION_COUNT: region_count_q <= cfg_i.data.data[CountW-1:0];
        CFG_IMAGE_BASE:   image_base_q   <= cfg_i.data.data;
        default:          ;
      endcase
    end
  end

  gracc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_data_i   (req_i.data),
    .out_valid_o (stg_valid[0]),
    .out_ready_i (stg_ready[0]),
    .out_data_o  (stg_data[0])
  );

  // Walk the table: one slot per stage, in ascending slot order.
  for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_slot
    gracc_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .region_count_i (region_count_q),
      .in_valid_i     (stg_valid[k]),
      .in_ready_o     (stg_ready[k]),
      .in_data_i      (stg_data[k]),
      .out_valid_o    (stg_valid[k+1]),
      .out_ready_i    (stg_ready[k+1]),
      .out_data_o     (stg_data[k+1])
    );
  end

  gracc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .image_base_i (image_base_q),
    .in_valid_i   (stg_valid[MAX_REGIONS]),
    .in_ready_o   (stg_ready[MAX_REGIONS]),
    .in_data_i    (stg_data[MAX_REGIONS]),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_data_o   (rsp_o.data)
  );

  // An empty access is settled as passing at the entry stage.
  a_zero_len_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.data.op == OP_CHECK &&
     req_i.data.access_size == '0)
    |=> (stg_valid[0] && stg_data[0].done && stg_data[0].status == ST_OK))
    else $error("empty access not settled as passing");

  // A range running past the top of the address space is flagged at entry.
  a_wrap_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.data.op == OP_CHECK &&
     req_i.data.access_size != '0 &&
     req_i.data.access_size > ~req_i.data.address)
    |=> (stg_valid[0] && stg_data[0].done && stg_data[0].status == ST_WRAP))
    else $error("wrapping range not flagged");

  // A check still open after the last slot comes out as unmapped.
  a_open_unmapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[MAX_REGIONS] && stg_ready[MAX_REGIONS] &&
     !stg_data[MAX_REGIONS].done && !stg_data[MAX_REGIONS].wr)
    |=> (rsp_o.valid && rsp_o.data.status == ST_UNMAPPED &&
         rsp_o.data.byte_offset == '0))
    else $error("open check not reported as unmapped");

endmodule
